[rtl/core/bdf_pkg.sv]
// shared constants, result type and hex digit helper for the byte stuffing deframer
package bdf_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int LEN_WIDTH   = 16;
  localparam int KIND_WIDTH  = 2;

  localparam logic [CFG_WIDTH-1:0] MAX_STORED_RESET = 16'd256;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] NIB_MASK  = 8'h0F;
  localparam logic [7:0] HEX_GAP   = 8'h07;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [KIND_WIDTH-1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_GOOD     = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_MISMATCH = 2'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    logic [7:0]            data_byte;
    logic [LEN_WIDTH-1:0]  payload_length;
    logic                  frame_end;
  } result_t;

  function automatic logic [7:0] hex_digit(input logic [7:0] nib);
    logic [7:0] d;
    d = (nib & NIB_MASK) + CHAR_ZERO;
    if (d > CHAR_NINE) begin
      d = d + HEX_GAP;
    end
    return d;
  endfunction

endpackage

[rtl/core/bdf_ifs.sv]
// channel interfaces: received bytes, results and configuration writes
interface bdf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bdf_res_if;
  logic                          valid;
  logic                          ready;
  logic [bdf_pkg::KIND_WIDTH-1:0] kind;
  logic [7:0]                    data_byte;
  logic [bdf_pkg::LEN_WIDTH-1:0] payload_length;
  logic                          frame_end;
  modport source (output valid, output kind, output data_byte, output payload_length,
                  output frame_end, input ready);
  modport sink (input valid, input kind, input data_byte, input payload_length,
                input frame_end, output ready);
endinterface

interface bdf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bdf_pkg::CFG_WIDTH-1:0] max_stored_bytes;
  modport source (output valid, output max_stored_bytes, input ready);
  modport sink (input valid, input max_stored_bytes, output ready);
endinterface

[rtl/core/bdf_in_stage.sv]
// input register holding one received byte until the deframer core takes it
module bdf_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       held_valid,
  output logic [7:0] held_byte,
  input  logic       take
);

  logic       valid;
  logic [7:0] byte_reg;

  assign in_ready   = !valid || take;
  assign held_valid = valid;
  assign held_byte  = byte_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_reg <= in_byte;
    end
  end

endmodule

[rtl/core/bdf_core.sv]
// frame state, unstuffing, check byte hold-back and xor check
module bdf_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [7:0]                    rx_byte,
  input  logic                          cfg_we,
  input  logic [bdf_pkg::CFG_WIDTH-1:0] cfg_data,
  output logic                          res_valid,
  output bdf_pkg::result_t              res
);

  localparam logic [1:0] MODE_HUNT  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_ESC   = 2'd2;
  localparam logic [bdf_pkg::COUNT_WIDTH-1:0] CNT_MAX = {bdf_pkg::COUNT_WIDTH{1'b1}};
  localparam logic [bdf_pkg::COUNT_WIDTH-1:0] CNT_TWO = bdf_pkg::COUNT_WIDTH'(2);
  localparam logic [bdf_pkg::COUNT_WIDTH-1:0] CNT_ONE = bdf_pkg::COUNT_WIDTH'(1);

  logic [bdf_pkg::CFG_WIDTH-1:0]   max_stored;
  logic [1:0]                      mode;
  logic [1:0]                      mode_next;
  logic [bdf_pkg::COUNT_WIDTH-1:0] count;
  logic [bdf_pkg::COUNT_WIDTH-1:0] count_next;
  logic [7:0]                      hold_older;
  logic [7:0]                      hold_older_next;
  logic [7:0]                      hold_newer;
  logic [7:0]                      hold_newer_next;
  logic [7:0]                      payload_xor;
  logic [7:0]                      payload_xor_next;

  logic [bdf_pkg::COUNT_WIDTH-1:0] count_inc;
  logic [bdf_pkg::COUNT_WIDTH-1:0] count_less_two;
  logic                            overflow;
  logic                            good;
  logic                            do_store;
  logic                            clear;
  logic [7:0]                      store_val;

  assign count_inc      = count + CNT_ONE;
  assign count_less_two = count - CNT_TWO;
  assign overflow       = (bdf_pkg::CFG_WIDTH'(count_inc) >= max_stored) ||
                          (count_inc >= CNT_MAX);
  assign good = (hold_older == bdf_pkg::hex_digit(payload_xor)) &&
                (hold_newer == bdf_pkg::hex_digit({4'h0, payload_xor[7:4]}));

  always_comb begin
    mode_next        = mode;
    count_next       = count;
    hold_older_next  = hold_older;
    hold_newer_next  = hold_newer;
    payload_xor_next = payload_xor;
    res_valid        = 1'b0;
    res              = '0;
    do_store         = 1'b0;
    clear            = 1'b0;
    store_val        = rx_byte;
    unique case (mode)
      MODE_FRAME: begin
        if (rx_byte == bdf_pkg::ESC_BYTE) begin
          mode_next = MODE_ESC;
        end else if (rx_byte == bdf_pkg::FLAG_BYTE) begin
          clear = 1'b1;
          if (count > CNT_TWO) begin
            res_valid          = 1'b1;
            res.kind           = good ? bdf_pkg::KIND_GOOD : bdf_pkg::KIND_MISMATCH;
            res.payload_length = bdf_pkg::LEN_WIDTH'(count_less_two);
            res.frame_end      = 1'b1;
            if (good) begin
              mode_next = MODE_HUNT;
            end
          end
        end else begin
          do_store = 1'b1;
        end
      end
      MODE_ESC: begin
        if (rx_byte == (bdf_pkg::FLAG_BYTE ^ bdf_pkg::ESC_XOR) ||
            rx_byte == (bdf_pkg::ESC_BYTE ^ bdf_pkg::ESC_XOR)) begin
          mode_next = MODE_FRAME;
          do_store  = 1'b1;
          store_val = rx_byte ^ bdf_pkg::ESC_XOR;
        end else begin
          mode_next = MODE_HUNT;
          clear     = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_HUNT;
        if (rx_byte == bdf_pkg::FLAG_BYTE) begin
          mode_next = MODE_FRAME;
          clear     = 1'b1;
        end
      end
    endcase
    if (do_store) begin
      if (overflow) begin
        res_valid          = 1'b1;
        res.kind           = bdf_pkg::KIND_TOO_LONG;
        res.payload_length = (count >= CNT_TWO) ?
                             bdf_pkg::LEN_WIDTH'(count_less_two) : '0;
        res.frame_end      = 1'b1;
        mode_next          = MODE_HUNT;
        clear              = 1'b1;
      end else begin
        hold_older_next = hold_newer;
        hold_newer_next = store_val;
        count_next      = count_inc;
        if (count >= CNT_TWO) begin
          payload_xor_next = payload_xor ^ hold_older;
          res_valid        = 1'b1;
          res.kind         = bdf_pkg::KIND_PAYLOAD;
          res.data_byte    = hold_older;
        end
      end
    end
    if (clear) begin
      count_next       = '0;
      hold_older_next  = '0;
      hold_newer_next  = '0;
      payload_xor_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_HUNT;
      count       <= '0;
      hold_older  <= '0;
      hold_newer  <= '0;
      payload_xor <= '0;
    end else if (fire) begin
      mode        <= mode_next;
      count       <= count_next;
      hold_older  <= hold_older_next;
      hold_newer  <= hold_newer_next;
      payload_xor <= payload_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_stored <= bdf_pkg::MAX_STORED_RESET;
    end else if (cfg_we) begin
      max_stored <= cfg_data;
    end
  end

  // hunting always starts from a cleared frame
  a_hunt_clear: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_HUNT |-> count == '0 && payload_xor == '0)
    else $error("hunting with frame state left over");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != CNT_MAX)
    else $error("stored count reached its ceiling");

  a_release_needs_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == bdf_pkg::KIND_PAYLOAD |-> count >= CNT_TWO)
    else $error("payload released before two bytes were held");

  a_end_marks_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.frame_end == (res.kind != bdf_pkg::KIND_PAYLOAD))
    else $error("frame end flag disagrees with result kind");

  a_good_hunts: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.kind == bdf_pkg::KIND_GOOD |=> mode == MODE_HUNT)
    else $error("good frame did not return to hunting");

endmodule

[rtl/core/bdf_out_stage.sv]
// result register that holds a finished result until the receiver takes it
module bdf_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bdf_pkg::result_t load_res,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output bdf_pkg::result_t out_res
);

  logic             valid;
  bdf_pkg::result_t res_reg;

  assign space     = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = res_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_reg <= load_res;
    end
  end

endmodule

[rtl/core/byte_stuffing_frame_deframer.sv]
// top level of the byte stuffing frame deframer
// channels: rx takes one stuffed byte per request, res gives one result per
// request (a payload byte or a frame status), cfg writes max_stored_bytes.
// a byte accepted on rx lands in the input register; once the result register
// has space, the core updates the frame state and, if the byte causes a
// result, loads the result register, which drives res.
// throughput is one byte per cycle while res is taken; the rate is set by the
// single state update per byte in the core.
// when res stalls with a result waiting, the held byte waits in the input
// register and rx ready drops once that register is full; nothing is lost.
// cfg is always ready and takes effect on the next byte; write it only idle.
// reset (synchronous, rst high) empties both registers, returns to hunting
// for a flag, clears the frame state and sets max_stored_bytes to 256.
module byte_stuffing_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  bdf_rx_if.sink     rx,
  bdf_res_if.source  res,
  bdf_cfg_if.sink    cfg
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             fire;
  logic             space;
  logic             core_valid;
  bdf_pkg::result_t core_res;
  bdf_pkg::result_t out_res;

  assign fire      = held_valid && space;
  assign cfg.ready = 1'b1;

  bdf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .in_byte    (rx.rx_byte),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .take       (fire)
  );

  bdf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (held_byte),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_data  (cfg.max_stored_bytes),
    .res_valid (core_valid),
    .res       (core_res)
  );

  bdf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && core_valid),
    .load_res  (core_res),
    .space     (space),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.kind           = out_res.kind;
  assign res.data_byte      = out_res.data_byte;
  assign res.payload_length = out_res.payload_length;
  assign res.frame_end      = out_res.frame_end;

endmodule

[tb/bdf_result_checker.sv]
`timescale 1ns / 100ps
// checker for the deframer: predicts results from accepted requests and compares them
module bdf_result_checker (
  input  logic clk,
  input  logic rst,
  bdf_rx_if    rx,
  bdf_res_if   res,
  bdf_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  typedef enum logic [1:0] {HUNTING, IN_FRAME, AFTER_ESC} link_mode_t;

  link_mode_t                      mode;
  logic [bdf_pkg::CFG_WIDTH-1:0]   frame_limit;
  logic [bdf_pkg::COUNT_WIDTH-1:0] stored_cnt;
  logic [7:0]                      older_byte;
  logic [7:0]                      newer_byte;
  logic [7:0]                      running_xor;
  bdf_pkg::result_t                expected_q[$];
  int                              errs;
  int                              seen;

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return bdf_pkg::CHAR_ZERO + {4'h0, nib};
    end
    return CHAR_UPPER_A + {4'h0, nib} - 8'd10;
  endfunction

  function automatic bdf_pkg::result_t make_result(
      input logic [bdf_pkg::KIND_WIDTH-1:0] k,
      input logic [7:0] d,
      input logic [bdf_pkg::LEN_WIDTH-1:0] len,
      input logic fin);
    bdf_pkg::result_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.payload_length = len;
    r.frame_end      = fin;
    return r;
  endfunction

  task automatic clear_frame();
    stored_cnt  = '0;
    older_byte  = 8'h00;
    newer_byte  = 8'h00;
    running_xor = 8'h00;
  endtask

  task automatic store_unstuffed(input logic [7:0] b);
    logic [bdf_pkg::COUNT_WIDTH:0]   next_cnt;
    logic [bdf_pkg::COUNT_WIDTH-1:0] released;
    logic [7:0]                      out_byte;
    next_cnt = {1'b0, stored_cnt} + 1'b1;
    released = (stored_cnt >= 2) ? stored_cnt - 2'd2 : '0;
    out_byte = older_byte;
    if (next_cnt >= {1'b0, frame_limit} ||
        next_cnt >= {1'b0, {bdf_pkg::COUNT_WIDTH{1'b1}}}) begin
      expected_q.push_back(make_result(bdf_pkg::KIND_TOO_LONG, 8'h00, released, 1'b1));
      mode = HUNTING;
      clear_frame();
    end else begin
      older_byte = newer_byte;
      newer_byte = b;
      if (stored_cnt >= 2) begin
        running_xor = running_xor ^ out_byte;
        expected_q.push_back(make_result(bdf_pkg::KIND_PAYLOAD, out_byte, '0, 1'b0));
      end
      stored_cnt = next_cnt[bdf_pkg::COUNT_WIDTH-1:0];
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic good;
    case (mode)
      IN_FRAME: begin
        if (b == bdf_pkg::ESC_BYTE) begin
          mode = AFTER_ESC;
        end else if (b == bdf_pkg::FLAG_BYTE) begin
          if (stored_cnt > 2) begin
            good = (older_byte == ascii_hex(running_xor[3:0])) &&
                   (newer_byte == ascii_hex(running_xor[7:4]));
            expected_q.push_back(make_result(
                good ? bdf_pkg::KIND_GOOD : bdf_pkg::KIND_MISMATCH, 8'h00,
                stored_cnt - 2'd2, 1'b1));
            if (good) begin
              mode = HUNTING;
            end
          end
          clear_frame();
        end else begin
          store_unstuffed(b);
        end
      end
      AFTER_ESC: begin
        if (b == (bdf_pkg::FLAG_BYTE ^ bdf_pkg::ESC_XOR) ||
            b == (bdf_pkg::ESC_BYTE ^ bdf_pkg::ESC_XOR)) begin
          mode = IN_FRAME;
          store_unstuffed(b ^ bdf_pkg::ESC_XOR);
        end else begin
          mode = HUNTING;
          clear_frame();
        end
      end
      default: begin
        mode = HUNTING;
        if (b == bdf_pkg::FLAG_BYTE) begin
          mode = IN_FRAME;
          clear_frame();
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    bdf_pkg::result_t want;
    if (rst) begin
      mode        = HUNTING;
      frame_limit = bdf_pkg::MAX_STORED_RESET;
      clear_frame();
      expected_q.delete();
      errs = 0;
      seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        frame_limit = cfg.max_stored_bytes;
      end
      if (rx.valid && rx.ready) begin
        deframe_byte(rx.rx_byte);
      end
      if (res.valid && res.ready) begin
        seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: kind %0d, data_byte %0d, payload_length %0d",
                 res.kind, res.data_byte, res.payload_length);
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", want.kind, res.kind);
          check_field("data_byte", want.data_byte, res.data_byte);
          check_field("payload_length", want.payload_length, res.payload_length);
          check_field("frame_end", want.frame_end, res.frame_end);
        end
      end
    end
    fail_count   <= errs;
    results_seen <= seen;
    pending      <= expected_q.size();
  end

endmodule

[tb/byte_stuffing_frame_deframer_tb.sv]
`timescale 1ns / 100ps
// testbench top for the deframer: reset, framed and noisy byte traffic, limit changes, verdict
module byte_stuffing_frame_deframer_tb;

  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SEND     = 1;
  localparam int IDLE_RECV     = 2;
  localparam int IDLE_BOTH     = 3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   results_seen;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_seq;
  int   bytes_sent;
  int   limit_writes;
  logic [7:0] tx_q[$];

  bdf_rx_if  rx_ch ();
  bdf_res_if res_ch ();
  bdf_cfg_if cfg_ch ();

  byte_stuffing_frame_deframer u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  bdf_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx_ch),
    .res          (res_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] ascii_digit(input logic [3:0] nib);
    logic [7:0] d;
    d = bdf_pkg::CHAR_ZERO + {4'h0, nib};
    if (d > bdf_pkg::CHAR_NINE) begin
      d = d + bdf_pkg::HEX_GAP;
    end
    return d;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(7);
    if (r == 0) begin
      return bdf_pkg::FLAG_BYTE;
    end
    if (r == 1) begin
      return bdf_pkg::ESC_BYTE;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic push_stuffed(input logic [7:0] b);
    if (b == bdf_pkg::FLAG_BYTE || b == bdf_pkg::ESC_BYTE) begin
      tx_q.push_back(bdf_pkg::ESC_BYTE);
      tx_q.push_back(b ^ bdf_pkg::ESC_XOR);
    end else begin
      tx_q.push_back(b);
    end
  endtask

  task automatic gen_traffic(input int n, input int max_pl, input int long_pl);
    int         pick;
    int         len;
    logic [7:0] x;
    logic [7:0] b;
    logic [7:0] chk_lo;
    logic [7:0] chk_hi;
    while (tx_q.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(long_pl, max_pl)
                                         : $urandom_range(max_pl);
        x = 8'h00;
        tx_q.push_back(bdf_pkg::FLAG_BYTE);
        repeat (len) begin
          b = pick_byte();
          x = x ^ b;
          push_stuffed(b);
        end
        chk_lo = ascii_digit(x[3:0]);
        chk_hi = ascii_digit(x[7:4]);
        if ($urandom_range(4) == 0) begin
          if ($urandom_range(1) == 0) begin
            chk_lo = 8'($urandom_range(255));
          end else begin
            chk_hi = 8'($urandom_range(255));
          end
        end
        push_stuffed(chk_lo);
        push_stuffed(chk_hi);
        tx_q.push_back(bdf_pkg::FLAG_BYTE);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(255)));
      end else if (pick < 88) begin
        tx_q.push_back(bdf_pkg::FLAG_BYTE);
        repeat ($urandom_range(4)) push_stuffed(pick_byte());
        tx_q.push_back(bdf_pkg::ESC_BYTE);
        b = 8'($urandom_range(255));
        if (b == (bdf_pkg::FLAG_BYTE ^ bdf_pkg::ESC_XOR) ||
            b == (bdf_pkg::ESC_BYTE ^ bdf_pkg::ESC_XOR)) begin
          b = bdf_pkg::FLAG_BYTE;
        end
        tx_q.push_back(b);
      end else begin
        tx_q.push_back(bdf_pkg::FLAG_BYTE);
        repeat ($urandom_range(2)) push_stuffed(pick_byte());
        tx_q.push_back(bdf_pkg::FLAG_BYTE);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_all();
    while (tx_q.size() > 0) send_byte(tx_q.pop_front());
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [bdf_pkg::CFG_WIDTH-1:0] v);
    settle();
    cfg_ch.valid            <= 1'b1;
    cfg_ch.max_stored_bytes <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    limit_writes++;
  endtask

  task automatic set_idle(input int sel);
    case (sel)
      IDLE_SEND: begin
        send_idle_pct  = 62;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 62;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 12;
        recv_stall_pct = 12;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic run_phase(input logic [bdf_pkg::CFG_WIDTH-1:0] lim, input int sel,
                           input int n, input int max_pl, input int long_pl);
    write_limit(lim);
    set_idle(sel);
    gen_traffic(n, max_pl, long_pl);
    send_all();
  endtask

  initial begin : stimulus
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq       = 0;
    bytes_sent     = 0;
    limit_writes   = 0;
    rst                     <= 1'b1;
    rx_ch.valid             <= 1'b0;
    rx_ch.rx_byte           <= 8'h00;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.max_stored_bytes <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ignored bytes, short frame, good frame, stuffed mismatch, bad escapes, hex letters
    tx_q = '{8'h00, 8'hFF, bdf_pkg::ESC_BYTE,
             bdf_pkg::FLAG_BYTE, 8'h41, bdf_pkg::FLAG_BYTE,
             8'h00, 8'h30, 8'h30, bdf_pkg::FLAG_BYTE,
             bdf_pkg::FLAG_BYTE, bdf_pkg::ESC_BYTE, bdf_pkg::FLAG_BYTE ^ bdf_pkg::ESC_XOR,
             bdf_pkg::ESC_BYTE, bdf_pkg::ESC_BYTE ^ bdf_pkg::ESC_XOR,
             8'h41, 8'h42, bdf_pkg::FLAG_BYTE,
             bdf_pkg::ESC_BYTE, 8'h00,
             bdf_pkg::FLAG_BYTE, bdf_pkg::ESC_BYTE, bdf_pkg::FLAG_BYTE,
             bdf_pkg::FLAG_BYTE, 8'hAF, 8'h46, 8'h41, bdf_pkg::FLAG_BYTE};
    send_all();

    write_limit(bdf_pkg::MAX_STORED_RESET);
    set_idle(IDLE_NONE);
    hold_seq++;
    gen_traffic(300, 12, 270);
    send_all();

    run_phase(16'd3, IDLE_SEND, 120, 3, 5);
    run_phase(16'd16, IDLE_RECV, 250, 10, 20);
    run_phase(16'hFFFF, IDLE_BOTH, 250, 12, 40);
    run_phase(16'($urandom_range(64, 4)), IDLE_NONE, 200, 16, 80);
    run_phase(16'd0, IDLE_NONE, 20, 3, 4);
    run_phase(16'd1, IDLE_NONE, 20, 3, 4);
    run_phase(16'd2, IDLE_SEND, 20, 3, 4);
    run_phase(16'($urandom_range(65535, 3)), IDLE_BOTH, 100, 12, 30);

    settle();
    $display("summary: %0d bytes sent over %0d limit settings, %0d results checked",
             bytes_sent, limit_writes, results_seen);
    $display("summary: good, mismatched, short, escaped and overlong frames under all stall modes");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[byte_stuffing_frame_deframer.f]
rtl/core/bdf_pkg.sv
rtl/core/bdf_ifs.sv
rtl/core/bdf_in_stage.sv
rtl/core/bdf_core.sv
rtl/core/bdf_out_stage.sv
rtl/core/byte_stuffing_frame_deframer.sv
tb/bdf_result_checker.sv
tb/byte_stuffing_frame_deframer_tb.sv
